// ===== hdl/sem_pkg.sv =====
// package for the sobel edge magnitude block
// types and sizes shared by controller, datapath and top level
package sem_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int CFG_W   = 11;
  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture pixel, read line stores
    logic calc;    // window is valid, compute gradient
    logic sq_start;
    logic shift;   // shift window, write line stores
  } sem_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sq_done;
  } sem_sts_t;
endpackage

// ===== hdl/sobel_edge_magnitude.sv =====
// top level of the sobel edge magnitude block
// ties sem_ctrl and sem_dp together; uses sem_pkg
//
// usage:
//  - input channel in_valid/in_stall/in_pixel takes grey pixels in raster order
//  - output channel out_valid/out_stall carries out_x, out_y, out_edge_value and
//    out_frame_end, exactly one result transaction per input transaction
//  - cfg_we/cfg_index/cfg_data write image_width (0) and image_height (1),
//    values saturate to 3..MAX; write only while idle
//  - each pixel passes through a line store read, a gradient step, the
//    bit-serial square root and an output step; the next pixel is accepted
//    only once the block is back in idle, so one pixel is in flight at a time
//  - reset clears counters, window and output valid and restores size 1024,
//    saturated to MAX; line store contents are undefined until written
//  - a stalled result holds; the block waits in its output state until the
//    output register is free
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sem_pkg::PIX_W-1:0]   in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sem_pkg::COORD_W-1:0] out_x,
  output logic [sem_pkg::COORD_W-1:0] out_y,
  output logic [sem_pkg::PIX_W-1:0]   out_edge_value,
  output logic                        out_frame_end
);
  import sem_pkg::*;

  sem_cmd_t cmd;
  sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts));

  sem_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_pixel(in_pixel), .cmd(cmd), .sts(sts),
    .out_x(out_x), .out_y(out_y), .out_edge_value(out_edge_value),
    .out_frame_end(out_frame_end));
endmodule

// ===== hdl/sem_ram.sv =====
// generic single port ram with registered read
// no package dependency
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/sem_ctrl.sv =====
// controller of the sobel edge magnitude block
// sequences load, compute, square root and output; uses sem_pkg
module sem_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output sem_pkg::sem_cmd_t  cmd,
  input  sem_pkg::sem_sts_t  sts
);
  import sem_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = ovld_r;

  // next state
  always_comb begin
    state_nxt    = state_r;
    ovld_nxt     = ovld_r;
    cmd          = '0;
    if (ovld_r && !out_stall) ovld_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        cmd.load  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: begin
        cmd.calc     = 1'b1;
        cmd.sq_start = 1'b1;
        state_nxt    = ST_SQRT;
      end
      ST_SQRT: if (sts.sq_done) state_nxt = ST_OUT;
      ST_OUT: if (!ovld_r || !out_stall) begin
        cmd.shift = 1'b1;
        ovld_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // a result is only presented from the output state
  a_shift_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |=> out_valid) else $error("shift without result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> in_stall) else $error("accept while busy");
  a_load_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_READ) else $error("load not followed by read");
endmodule

// ===== hdl/sem_dp.sv =====
// datapath of the sobel edge magnitude block
// line stores, window, counters, gradient and iterative square root; uses sem_pkg, sem_ram
module sem_dp #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  input  logic [sem_pkg::PIX_W-1:0]     in_pixel,
  input  sem_pkg::sem_cmd_t             cmd,
  output sem_pkg::sem_sts_t             sts,
  output logic [sem_pkg::COORD_W-1:0]   out_x,
  output logic [sem_pkg::COORD_W-1:0]   out_y,
  output logic [sem_pkg::PIX_W-1:0]     out_edge_value,
  output logic                          out_frame_end
);
  import sem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int SW = (CW > RW) ? CW : RW;

  logic [CW-1:0] width_r;
  logic [RW-1:0] height_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] old_q, new_q;
  logic [AW-1:0]    addr;
  logic [COORD_W-1:0] ox_r, oy_r;
  logic               last_r, inner_r;
  logic [16:0]        s_r;
  logic [7:0]         root_r;
  logic [3:0]         bit_r;
  logic               busy_r;

  // size registers saturate into range
  function automatic logic [SW-1:0] clamp_sz(logic [CFG_W-1:0] v, int hi);
    if (v < CFG_W'(3)) return SW'(3);
    if (32'(v) > hi) return SW'(hi);
    return SW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CW'(clamp_sz(CFG_W'(1024), MAX_WIDTH));
      height_r <= RW'(clamp_sz(CFG_W'(1024), MAX_HEIGHT));
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_WIDTH) width_r <= CW'(clamp_sz(cfg_data, MAX_WIDTH));
      else height_r <= RW'(clamp_sz(cfg_data, MAX_HEIGHT));
    end
  end

  assign addr = col_r[AW-1:0];

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(cmd.shift), .addr(addr), .wdata(new_q), .rdata(old_q));
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk(clk), .we(cmd.shift), .addr(addr), .wdata(pix_r), .rdata(new_q));

  // stage the input pixel
  always_ff @(posedge clk) begin
    if (cmd.load) pix_r <= in_pixel;
  end

  // coordinates and border decision
  logic last_col, last_px;
  assign last_col = (CW'(col_r) + CW'(1) >= width_r);
  assign last_px  = last_col && (RW'(row_r) + RW'(1) >= height_r);

  // gradient, registered
  logic signed [11:0] gx, gy;
  logic [10:0] ax, ay;
  logic [21:0] sq;
  always_comb begin
    gx = 12'(signed'({4'd0, old_q})) - 12'(signed'({4'd0, win_r[0]}))
       + 12'(signed'({3'd0, new_q, 1'b0})) - 12'(signed'({3'd0, win_r[2], 1'b0}))
       + 12'(signed'({4'd0, pix_r})) - 12'(signed'({4'd0, win_r[4]}));
    gy = 12'(signed'({4'd0, win_r[0]})) + 12'(signed'({3'd0, win_r[1], 1'b0}))
       + 12'(signed'({4'd0, old_q})) - 12'(signed'({4'd0, win_r[4]}))
       - 12'(signed'({3'd0, win_r[5], 1'b0})) - 12'(signed'({4'd0, pix_r}));
    ax = gx[11] ? 11'(-gx) : gx[10:0];
    ay = gy[11] ? 11'(-gy) : gy[10:0];
    sq = 22'(ax) * 22'(ax) + 22'(ay) * 22'(ay);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      last_r <= last_px;
      if (row_r == '0) begin
        ox_r <= COORD_W'(col_r); oy_r <= COORD_W'(height_r - RW'(1)); inner_r <= 1'b0;
      end else if (col_r == '0) begin
        ox_r <= COORD_W'(width_r - CW'(1)); oy_r <= COORD_W'(row_r - RW'(1));
        inner_r <= 1'b0;
      end else begin
        ox_r <= COORD_W'(col_r - CW'(1)); oy_r <= COORD_W'(row_r - RW'(1));
        inner_r <= (col_r != CW'(1)) && (row_r != RW'(1))
                && (col_r < width_r) && (row_r < height_r);
      end
      s_r <= (sq >= 22'(65025)) ? 17'(65025) : sq[16:0];
    end
  end

  // restoring square root, one bit per cycle, msb first
  logic [7:0]  trial;
  logic [15:0] tsq;
  assign trial = root_r | (8'd1 << bit_r[2:0]);
  assign tsq   = 16'(trial) * 16'(trial);
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (cmd.sq_start) begin
      busy_r <= 1'b1; bit_r <= 4'd7; root_r <= '0;
    end else if (busy_r) begin
      if (17'(tsq) <= s_r) root_r <= trial;
      if (bit_r == 4'd0) busy_r <= 1'b0;
      else bit_r <= bit_r - 4'd1;
    end
  end
  assign sts.sq_done = busy_r && (bit_r == 4'd0);

  // window shift, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (cmd.shift) begin
      win_r[0] <= win_r[1]; win_r[1] <= old_q;
      win_r[2] <= win_r[3]; win_r[3] <= new_q;
      win_r[4] <= win_r[5]; win_r[5] <= pix_r;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_px ? '0 : row_r + RW'(1);
      end else col_r <= col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      out_x <= ox_r; out_y <= oy_r; out_frame_end <= last_r;
      out_edge_value <= inner_r ? root_r : '0;
    end
  end
endmodule
